// ----- design/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared widths, codes and types of the pressure trend tracker.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int PRESSURE_W = 21;
    localparam int ELAPSED_W  = 16;
    localparam int INTERVAL_W = 22;
    localparam int THRESH_W   = 16;
    localparam int ACC_W      = 23;
    localparam int CHANGE_W   = 22;
    localparam int TREND_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 22;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 88;

    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = 6;

    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL   = 22'd1024;
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL   = 22'd300000;
    localparam logic [THRESH_W-1:0]   RST_THRESH     = 16'd240;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 1'd1;

    typedef enum logic [TREND_W-1:0] {
        TREND_UNKNOWN = 2'd0,
        TREND_FALLING = 2'd1,
        TREND_STEADY  = 2'd2,
        TREND_RISING  = 2'd3
    } trend_t;

    // one history push handed from front to back
    typedef struct packed {
        logic [PRESSURE_W-1:0] avg;
        logic                  last;
    } job_t;

endpackage

// ----- design/ptt_front.sv -----
// ----------------------------------------------------------------------------
// ptt_front
// Takes samples, keeps the short ring and the millisecond accumulator, and
// issues one push job per completed interval with the rounded short mean.
// ----------------------------------------------------------------------------
module ptt_front #(
    parameter int SHORT_DEPTH = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ptt_pkg::PRESSURE_W-1:0]      in_pressure,
    input  logic [ptt_pkg::ELAPSED_W-1:0]       in_elapsed,
    input  logic [ptt_pkg::INTERVAL_W-1:0]      interval,
    output logic                                job_valid,
    input  logic                                job_ready,
    output ptt_pkg::job_t                       job
);
    import ptt_pkg::*;

    localparam int CW = $clog2(SHORT_DEPTH + 1);
    localparam int DW = PRESSURE_W + CW;
    localparam int RW = CW + 1;
    localparam int IW = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
    localparam int NW = $clog2(DW + 1);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_CHK  = 4'b0010,
        F_DIV  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t                state_reg, state_next;
    logic [PRESSURE_W-1:0]  ring [SHORT_DEPTH];
    logic [IW-1:0]          wr_reg, wr_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [DW-1:0]          sum_reg, sum_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [DW-1:0]          q_reg, q_next;
    logic [RW-1:0]          rem_reg, rem_next;
    logic [NW-1:0]          it_reg, it_next;
    logic [RES_CNT_W-1:0]   n_reg, n_next;

    logic [INTERVAL_W-1:0]  ivl;
    logic [ACC_W-1:0]       acc_left;
    logic [RW-1:0]          rem_sh;
    logic                   full;
    logic                   take;
    logic                   is_last;

    assign ivl      = (interval < MIN_INTERVAL) ? MIN_INTERVAL : interval;
    assign full     = (cnt_reg == CW'(SHORT_DEPTH));
    assign take     = (state_reg == F_IDLE) && in_valid;
    assign acc_left = acc_reg - ACC_W'(ivl);
    assign is_last  = (acc_left < ACC_W'(ivl)) || (n_reg == RES_CNT_W'(MAX_RESULTS - 1));
    assign rem_sh   = {rem_reg[RW-2:0], q_reg[DW-1]};

    assign in_ready  = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_PUSH);
    assign job.avg   = q_reg[PRESSURE_W-1:0];
    assign job.last  = is_last;

    always_ff @(posedge aclk) begin
        if (take) begin
            ring[wr_reg] <= in_pressure;
        end
    end

    always_comb begin
        state_next = state_reg;
        wr_next    = wr_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        it_next    = it_reg;
        n_next     = n_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    wr_next  = (wr_reg == IW'(SHORT_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
                    cnt_next = full ? cnt_reg : cnt_reg + 1'b1;
                    sum_next = sum_reg + DW'(in_pressure) - (full ? DW'(ring[wr_reg]) : '0);
                    acc_next = acc_reg + ACC_W'(in_elapsed);
                    state_next = F_CHK;
                end
            end
            F_CHK: begin
                if (acc_reg >= ACC_W'(ivl)) begin
                    q_next     = sum_reg + DW'(cnt_reg >> 1);
                    rem_next   = '0;
                    it_next    = '0;
                    state_next = F_DIV;
                end else begin
                    state_next = F_IDLE;
                end
            end
            F_DIV: begin
                if (rem_sh >= RW'(cnt_reg)) begin
                    rem_next = rem_sh - RW'(cnt_reg);
                    q_next   = {q_reg[DW-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[DW-2:0], 1'b0};
                end
                it_next = it_reg + 1'b1;
                if (it_reg == NW'(DW - 1)) begin
                    n_next     = '0;
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (job_ready) begin
                    acc_next = acc_left;
                    n_next   = n_reg + 1'b1;
                    if (is_last) begin
                        state_next = F_IDLE;
                    end
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            wr_reg    <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            acc_reg   <= '0;
        end else begin
            state_reg <= state_next;
            wr_reg    <= wr_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        it_reg  <= it_next;
        n_reg   <= n_next;
    end

endmodule

// ----- design/ptt_fifo.sv -----
// ----------------------------------------------------------------------------
// ptt_fifo
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module ptt_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ptt_pkg::job_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ptt_pkg::job_t  out_data
);
    import ptt_pkg::*;

    job_t        mem [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= in_data;
        end
    end

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- design/ptt_back.sv -----
// ----------------------------------------------------------------------------
// ptt_back
// Writes each pushed mean into the history memory, scans the history for
// min, max, change and block trend vote, and holds the result register.
// ----------------------------------------------------------------------------
module ptt_back #(
    parameter int HISTORY_DEPTH = 256,
    parameter int TREND_SAMPLES = 36,
    parameter int BLOCK_LEN     = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             job_valid,
    output logic                             job_ready,
    input  ptt_pkg::job_t                    job,
    input  logic [ptt_pkg::THRESH_W-1:0]     thresh,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ptt_pkg::PRESSURE_W-1:0]   out_avg,
    output logic [ptt_pkg::PRESSURE_W-1:0]   out_min,
    output logic [ptt_pkg::PRESSURE_W-1:0]   out_max,
    output logic [ptt_pkg::CHANGE_W-1:0]     out_change,
    output logic [ptt_pkg::TREND_W-1:0]      out_trend,
    output logic                             out_last
);
    import ptt_pkg::*;

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int HCW  = $clog2(HISTORY_DEPTH + 1);
    localparam int KW   = $clog2(HISTORY_DEPTH + TREND_SAMPLES + 1);
    localparam int NBLK = TREND_SAMPLES / BLOCK_LEN;
    localparam int HALF = NBLK / 2;
    localparam int USED = NBLK * BLOCK_LEN;
    localparam int BCW  = $clog2(NBLK + 1);
    localparam int BIW  = $clog2(BLOCK_LEN);
    localparam int BSW  = PRESSURE_W + $clog2(BLOCK_LEN + 1);
    localparam int LW   = THRESH_W + $clog2(BLOCK_LEN + 1);
    localparam int DFW  = BSW + 1;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_SCAN = 3'b010,
        B_OUT  = 3'b100
    } bstate_t;

    bstate_t                state_reg, state_next;
    logic [PRESSURE_W-1:0]  hist [HISTORY_DEPTH];
    logic [PRESSURE_W-1:0]  rd_data_reg;

    logic [AW-1:0]          head_reg, head_next;
    logic [HCW-1:0]         count_reg, count_next;
    logic [AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [KW-1:0]          ki_reg, ki_next;
    logic [KW-1:0]          rk_reg, rk_next;
    logic                   rv_reg, rv_next;
    logic [PRESSURE_W-1:0]  newest_reg, newest_next;
    logic                   last_reg, last_next;
    logic [PRESSURE_W-1:0]  mn_reg, mn_next;
    logic [PRESSURE_W-1:0]  mx_reg, mx_next;
    logic [PRESSURE_W-1:0]  old_reg, old_next;
    logic [BSW-1:0]         bsum_reg, bsum_next;
    logic [BIW-1:0]         bi_reg, bi_next;
    logic [BCW-1:0]         bidx_reg, bidx_next;
    logic                   blk_v_reg, blk_v_next;
    logic                   blk_first_reg, blk_first_next;
    logic [BSW-1:0]         blk_sum_reg, blk_sum_next;
    logic [BSW-1:0]         prev_reg, prev_next;
    logic [BCW-1:0]         ndown_reg, ndown_next;
    logic [BCW-1:0]         nup_reg, nup_next;
    logic [BCW-1:0]         nflat_reg, nflat_next;
    logic [LW-1:0]          lim_reg, lim_next;
    logic [CHANGE_W-1:0]    change_reg, change_next;
    trend_t                 trend_reg, trend_next;

    logic                   ov_reg, ov_next;
    logic [PRESSURE_W-1:0]  o_avg_reg, o_min_reg, o_max_reg;
    logic [CHANGE_W-1:0]    o_change_reg;
    trend_t                 o_trend_reg;
    logic                   o_last_reg;

    logic                   pop;
    logic                   issue;
    logic                   load;
    logic signed [DFW-1:0]  diff;
    logic signed [DFW-1:0]  lim_s;
    logic [BSW-1:0]         newer;
    logic [CHANGE_W-1:0]    change_c;
    trend_t                 vote;

    assign job_ready = (state_reg == B_IDLE);
    assign pop       = job_ready && job_valid;
    assign issue     = (state_reg == B_SCAN) && (ki_reg < KW'(count_reg));
    assign load      = (state_reg == B_OUT) && (!ov_reg || out_ready);

    assign newer = blk_first_reg ? blk_sum_reg : prev_reg;
    assign diff  = $signed({1'b0, newer}) - $signed({1'b0, blk_sum_reg});
    assign lim_s = $signed(DFW'(lim_reg));

    always_comb begin
        if (ndown_reg >= BCW'(HALF)) begin
            vote = TREND_FALLING;
        end else if (nup_reg >= BCW'(HALF)) begin
            vote = TREND_RISING;
        end else if (nflat_reg >= BCW'(HALF)) begin
            vote = TREND_STEADY;
        end else begin
            vote = TREND_UNKNOWN;
        end
    end

    assign change_c = CHANGE_W'({1'b0, newest_reg}) - CHANGE_W'({1'b0, old_reg});

    always_ff @(posedge aclk) begin
        if (pop) begin
            hist[head_reg] <= job.avg;
        end
        if (issue) begin
            rd_data_reg <= hist[rd_ptr_reg];
        end
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        ki_next        = ki_reg;
        rk_next        = rk_reg;
        rv_next        = 1'b0;
        newest_next    = newest_reg;
        last_next      = last_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        old_next       = old_reg;
        bsum_next      = bsum_reg;
        bi_next        = bi_reg;
        bidx_next      = bidx_reg;
        blk_v_next     = 1'b0;
        blk_first_next = blk_first_reg;
        blk_sum_next   = blk_sum_reg;
        prev_next      = prev_reg;
        ndown_next     = ndown_reg;
        nup_next       = nup_reg;
        nflat_next     = nflat_reg;
        lim_next       = lim_reg;
        change_next    = change_reg;
        trend_next     = trend_reg;
        ov_next        = ov_reg && !out_ready;

        case (state_reg)
            B_IDLE: begin
                if (job_valid) begin
                    newest_next = job.avg;
                    last_next   = job.last;
                    head_next   = (head_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next  = (count_reg == HCW'(HISTORY_DEPTH)) ? count_reg
                                                                     : count_reg + 1'b1;
                    rd_ptr_next = head_reg;
                    ki_next     = '0;
                    bsum_next   = '0;
                    bi_next     = '0;
                    bidx_next   = '0;
                    ndown_next  = '0;
                    nup_next    = '0;
                    nflat_next  = '0;
                    lim_next    = LW'(thresh) * LW'(BLOCK_LEN);
                    state_next  = B_SCAN;
                end
            end
            B_SCAN: begin
                if (issue) begin
                    rd_ptr_next = (rd_ptr_reg == '0) ? AW'(HISTORY_DEPTH - 1) : rd_ptr_reg - 1'b1;
                    ki_next     = ki_reg + 1'b1;
                    rk_next     = ki_reg;
                    rv_next     = 1'b1;
                end else if (!rv_reg) begin
                    state_next = B_OUT;
                end

                if (rv_reg) begin
                    if (rk_reg == '0) begin
                        mn_next = rd_data_reg;
                        mx_next = rd_data_reg;
                    end else begin
                        if (rd_data_reg < mn_reg) mn_next = rd_data_reg;
                        if (rd_data_reg > mx_reg) mx_next = rd_data_reg;
                    end
                    if (rk_reg == KW'(TREND_SAMPLES)) begin
                        old_next = rd_data_reg;
                    end
                    if (rk_reg < KW'(USED)) begin
                        if (bi_reg == BIW'(BLOCK_LEN - 1)) begin
                            blk_v_next     = 1'b1;
                            blk_sum_next   = bsum_reg + BSW'(rd_data_reg);
                            blk_first_next = (bidx_reg == '0);
                            bsum_next      = '0;
                            bi_next        = '0;
                            bidx_next      = bidx_reg + 1'b1;
                        end else begin
                            bsum_next = bsum_reg + BSW'(rd_data_reg);
                            bi_next   = bi_reg + 1'b1;
                        end
                    end
                end

                // block compare, on the registered block sum after the scan closes a block
                if (blk_v_reg) begin
                    prev_next = blk_sum_reg;
                    if (diff < -lim_s) begin
                        ndown_next = ndown_reg + 1'b1;
                    end else if (diff > lim_s) begin
                        nup_next = nup_reg + 1'b1;
                    end else begin
                        nflat_next = nflat_reg + 1'b1;
                    end
                end
            end
            B_OUT: begin
                if (load) begin
                    if (KW'(count_reg) > KW'(TREND_SAMPLES)) begin
                        change_next = change_c;
                        trend_next  = vote;
                    end
                    ov_next    = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= B_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            change_reg <= '0;
            trend_reg  <= TREND_UNKNOWN;
            ov_reg     <= 1'b0;
            rv_reg     <= 1'b0;
            blk_v_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            change_reg <= change_next;
            trend_reg  <= trend_next;
            ov_reg     <= ov_next;
            rv_reg     <= rv_next;
            blk_v_reg  <= blk_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg    <= rd_ptr_next;
        ki_reg        <= ki_next;
        rk_reg        <= rk_next;
        newest_reg    <= newest_next;
        last_reg      <= last_next;
        mn_reg        <= mn_next;
        mx_reg        <= mx_next;
        old_reg       <= old_next;
        bsum_reg      <= bsum_next;
        bi_reg        <= bi_next;
        bidx_reg      <= bidx_next;
        blk_first_reg <= blk_first_next;
        blk_sum_reg   <= blk_sum_next;
        prev_reg      <= prev_next;
        ndown_reg     <= ndown_next;
        nup_reg       <= nup_next;
        nflat_reg     <= nflat_next;
        lim_reg       <= lim_next;
        if (load) begin
            o_avg_reg    <= newest_reg;
            o_min_reg    <= mn_reg;
            o_max_reg    <= mx_reg;
            o_change_reg <= change_next;
            o_trend_reg  <= trend_next;
            o_last_reg   <= last_reg;
        end
    end

    assign out_valid  = ov_reg;
    assign out_avg    = o_avg_reg;
    assign out_min    = o_min_reg;
    assign out_max    = o_max_reg;
    assign out_change = o_change_reg;
    assign out_trend  = o_trend_reg;
    assign out_last   = o_last_reg;

endmodule

// ----- design/pressure_trend_tracker.sv -----
// ----------------------------------------------------------------------------
// pressure_trend_tracker
// Pressure history tracker with min/max, long-term change and trend vote.
//
// s_ channel: one beat per sample (pressure, elapsed ms). A sample adds to a
// short running mean and to a millisecond accumulator; every full interval
// in the accumulator pushes the rounded short mean into the history and
// gives one m_ beat (at most 64 per sample), tlast on the final one.
// A sample that completes no interval gives no beat.
// A sample that pushes nothing returns the front to idle after the interval
// check; otherwise the front runs the rounding divider and then hands one
// job per push to a two-entry queue. The back handles each push by reading
// the whole filled history through one memory read port and takes no new
// job until that scan and its result load are done.
// Config writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once and
// are meant for idle periods only.
// Reset clears counts, accumulator and trend state; the history memory is
// not cleared. A stalled m_tready holds the result register; the back then
// waits, the queue fills and the front stalls on its push with s_tready low.
// ----------------------------------------------------------------------------
module pressure_trend_tracker #(
    parameter int SHORT_DEPTH   = 5,
    parameter int HISTORY_DEPTH = 256,
    parameter int TREND_SAMPLES = 36,
    parameter int BLOCK_LEN     = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ptt_pkg::S_TDATA_W-1:0]    s_tdata,   // pressure, elapsed_ms
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ptt_pkg::M_TDATA_W-1:0]    m_tdata,   // average, window_min, window_max, change, trend
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ptt_pkg::*;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [THRESH_W-1:0]   thresh_reg;

    logic                  job_valid, job_ready;
    job_t                  job;
    logic                  q_valid, q_ready;
    job_t                  q_job;

    logic [PRESSURE_W-1:0] avg, wmin, wmax;
    logic [CHANGE_W-1:0]   change;
    logic [TREND_W-1:0]    trend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= RST_INTERVAL;
            thresh_reg   <= RST_THRESH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_INTERVAL: interval_reg <= cfg_wdata[INTERVAL_W-1:0];
                REG_THRESH:   thresh_reg   <= cfg_wdata[THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ptt_front #(
        .SHORT_DEPTH (SHORT_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_pressure (s_tdata[PRESSURE_W-1:0]),
        .in_elapsed  (s_tdata[PRESSURE_W +: ELAPSED_W]),
        .interval    (interval_reg),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job)
    );

    ptt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (job_valid),
        .in_ready  (job_ready),
        .in_data   (job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_job)
    );

    ptt_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TREND_SAMPLES (TREND_SAMPLES),
        .BLOCK_LEN     (BLOCK_LEN)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (q_valid),
        .job_ready  (q_ready),
        .job        (q_job),
        .thresh     (thresh_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_avg    (avg),
        .out_min    (wmin),
        .out_max    (wmax),
        .out_change (change),
        .out_trend  (trend),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, trend, change, wmax, wmin, avg};

endmodule

// ----- design/ptt_checker.sv -----
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks on the result channel of the pressure trend tracker.
// ----------------------------------------------------------------------------
module ptt_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ptt_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             m_tlast
);
    import ptt_pkg::*;

    logic [PRESSURE_W-1:0] c_avg, c_min, c_max;

    assign c_avg = m_tdata[PRESSURE_W-1:0];
    assign c_min = m_tdata[PRESSURE_W +: PRESSURE_W];
    assign c_max = m_tdata[2*PRESSURE_W +: PRESSURE_W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_min_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> c_min <= c_max)
        else $error("window min above window max");

    a_avg_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (c_min <= c_avg) && (c_avg <= c_max))
        else $error("pushed mean outside the window");

endmodule

bind pressure_trend_tracker ptt_checker u_ptt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
